@@ src/v4v6_pkg.sv @@
// Package for the IPv4-embedded IPv6 translator: carry type passed along the
// cell chain, length codes and the address compose/extract functions.
// Used by the cell and top-level files of the block; depends on nothing.
package v4v6_pkg;

  localparam int IDX_W = 6;

  localparam logic [1:0] ACT_ADD = 2'd0;
  localparam logic [1:0] ACT_DEL = 2'd1;
  localparam logic [1:0] ACT_CMP = 2'd2;
  localparam logic [1:0] ACT_EXT = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_BAD_LEN = 2'd1;
  localparam logic [1:0] ST_NO_ENTRY = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  localparam logic [2:0] CODE_96 = 3'd5;
  localparam logic [95:0] WKP = {8'h00, 8'h64, 8'hff, 8'h9b, 64'h0};

  typedef struct packed {
    logic go;
    logic hit;
    logic [IDX_W-1:0] hit_idx;
    logic [63:0] hit_hi;
    logic [31:0] hit_mid;
    logic [2:0] hit_code;
    logic fb;
    logic [63:0] fb_hi;
    logic [31:0] fb_mid;
    logic [2:0] fb_code;
    logic free;
    logic [IDX_W-1:0] free_idx;
  } carry_t;

  typedef struct packed {
    logic en;
    logic clear;
    logic fresh;
    logic [IDX_W-1:0] idx;
  } wr_t;

  function automatic logic [3:0] len_code(input logic [7:0] len);
    case (len)
      8'd32: len_code = 4'b1000;
      8'd40: len_code = 4'b1001;
      8'd48: len_code = 4'b1010;
      8'd56: len_code = 4'b1011;
      8'd64: len_code = 4'b1100;
      8'd96: len_code = 4'b1101;
      default: len_code = 4'b0000;
    endcase
  endfunction

  function automatic logic [4:0] nbytes(input logic [2:0] code);
    case (code)
      3'd0: nbytes = 5'd4;
      3'd1: nbytes = 5'd5;
      3'd2: nbytes = 5'd6;
      3'd3: nbytes = 5'd7;
      3'd4: nbytes = 5'd8;
      default: nbytes = 5'd12;
    endcase
  endfunction

  function automatic logic [3:0] opos(input logic [2:0] code, input logic [1:0] k);
    logic [15:0] row;
    case (code)
      3'd0: row = 16'h4567;
      3'd1: row = 16'h5679;
      3'd2: row = 16'h679a;
      3'd3: row = 16'h79ab;
      3'd4: row = 16'h9abc;
      default: row = 16'hcdef;
    endcase
    opos = row[15 - 4 * k -: 4];
  endfunction

  function automatic logic [127:0] compose(input logic [2:0] code,
                                           input logic [95:0] pfx,
                                           input logic [31:0] v4);
    logic [127:0] w;
    logic [4:0] nb;
    w = '0;
    nb = nbytes(code);
    for (int j = 0; j < 12; j++) begin
      if (5'(j) < nb) begin
        w[127 - 8 * j -: 8] = pfx[95 - 8 * j -: 8];
      end
    end
    for (int j = 0; j < 16; j++) begin
      for (int k = 0; k < 4; k++) begin
        if (opos(code, 2'(k)) == 4'(j)) begin
          w[127 - 8 * j -: 8] = v4[31 - 8 * k -: 8];
        end
      end
    end
    compose = w;
  endfunction

  function automatic logic [31:0] extract(input logic [2:0] code,
                                          input logic [127:0] a);
    logic [31:0] v;
    v = '0;
    for (int k = 0; k < 4; k++) begin
      for (int j = 0; j < 16; j++) begin
        if (opos(code, 2'(k)) == 4'(j)) begin
          v[31 - 8 * k -: 8] = a[127 - 8 * j -: 8];
        end
      end
    end
    extract = v;
  endfunction

endpackage

@@ src/v4v6_req_if.sv @@
// Request and response channel interfaces of the translator.
// Valid/ready handshake; no package dependency.
interface v4v6_req_if;
  logic valid;
  logic ready;
  logic [1:0] action;
  logic [31:0] tenant_id;
  logic [15:0] table_index;
  logic [63:0] addr_high;
  logic [63:0] addr_low;
  logic [7:0] prefix_len;
  logic [31:0] ipv4_addr;
  modport source(output valid, action, tenant_id, table_index, addr_high, addr_low,
                 prefix_len, ipv4_addr, input ready);
  modport sink(input valid, action, tenant_id, table_index, addr_high, addr_low,
               prefix_len, ipv4_addr, output ready);
endinterface

interface v4v6_rsp_if;
  logic valid;
  logic ready;
  logic [1:0] status;
  logic [63:0] ipv6_high;
  logic [63:0] ipv6_low;
  logic [31:0] ipv4_out;
  modport source(output valid, status, ipv6_high, ipv6_low, ipv4_out, input ready);
  modport sink(input valid, status, ipv6_high, ipv6_low, ipv4_out, output ready);
endinterface

@@ src/v4v6_cell.sv @@
// One prefix slot of the translator chain: holds the entry and folds its
// match into the carry handed to the next cell. Depends on v4v6_pkg.
module v4v6_cell #(
  parameter int IDX = 0
) (
  input  logic clk,
  input  logic rst,
  input  logic [1:0] action,
  input  logic [31:0] tenant_id,
  input  logic [15:0] table_index,
  input  logic [63:0] addr_high,
  input  logic [31:0] addr_mid,
  input  logic [2:0] code,
  input  v4v6_pkg::wr_t wr,
  input  v4v6_pkg::carry_t cin,
  output v4v6_pkg::carry_t cout
);
  logic valid;
  logic [31:0] tenant;
  logic [15:0] tbl;
  logic [63:0] phi;
  logic [31:0] pmid;
  logic [2:0] pcode;
  v4v6_pkg::carry_t c_next;
  logic lookup;
  logic mine;

  assign lookup = action[1];
  assign mine = wr.idx == v4v6_pkg::IDX_W'(IDX);

  always_comb begin
    c_next = cin;
    if (valid && !cin.hit) begin
      if (lookup ? (tbl == table_index) : (tenant == tenant_id)) begin
        c_next.hit = 1'b1;
        c_next.hit_idx = v4v6_pkg::IDX_W'(IDX);
        c_next.hit_hi = phi;
        c_next.hit_mid = pmid;
        c_next.hit_code = pcode;
      end else if (action == v4v6_pkg::ACT_CMP ? (tbl == 16'd0) : (tenant == 32'd0)) begin
        c_next.fb = 1'b1;
        c_next.fb_hi = phi;
        c_next.fb_mid = pmid;
        c_next.fb_code = pcode;
      end
    end
    if (!valid && !cin.free) begin
      c_next.free = 1'b1;
      c_next.free_idx = v4v6_pkg::IDX_W'(IDX);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cout.go <= 1'b0;
    end else begin
      cout.go <= cin.go;
    end
    cout.hit <= c_next.hit;
    cout.hit_idx <= c_next.hit_idx;
    cout.hit_hi <= c_next.hit_hi;
    cout.hit_mid <= c_next.hit_mid;
    cout.hit_code <= c_next.hit_code;
    cout.fb <= c_next.fb;
    cout.fb_hi <= c_next.fb_hi;
    cout.fb_mid <= c_next.fb_mid;
    cout.fb_code <= c_next.fb_code;
    cout.free <= c_next.free;
    cout.free_idx <= c_next.free_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (wr.en && mine) begin
      valid <= !wr.clear;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && mine && !wr.clear) begin
      if (wr.fresh) begin
        tenant <= tenant_id;
        tbl <= table_index;
      end
      phi <= addr_high;
      pmid <= addr_mid;
      pcode <= code;
    end
  end
endmodule

@@ src/ipv4_embedded_ipv6_translator.sv @@
// IPv4-embedded IPv6 translator top level: request register, chain of prefix
// cells and response register. Depends on v4v6_pkg, the channel interfaces
// and v4v6_cell.
//
// A word on the req channel adds or deletes a tenant prefix, or composes or
// extracts an address; each word yields exactly one word on the rsp channel.
// The request is registered, then a scan token walks the chain of
// PREFIX_ENTRIES cells, one cell per cycle, collecting the tenant or table
// match, the fallback entry and the lowest free slot. When it leaves the last
// cell the table is written and the response registered.
// Only one request is in flight at a time, so a new word is not accepted until
// the response to the last one has been taken.
// Reset empties the table and drops any request in flight. When the receiver
// stalls, the response holds on rsp and req stays not ready until it is taken.
module ipv4_embedded_ipv6_translator #(
  parameter int PREFIX_ENTRIES = 8
) (
  input logic clk,
  input logic rst,
  v4v6_req_if.sink req,
  v4v6_rsp_if.source rsp
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_OUT = 2'd2;

  logic [1:0] state;
  logic start;
  logic [1:0] action;
  logic [31:0] tenant_id;
  logic [15:0] table_index;
  logic [63:0] addr_high;
  logic [63:0] addr_low;
  logic [7:0] prefix_len;
  logic [31:0] ipv4_addr;
  logic [3:0] lc;
  v4v6_pkg::carry_t chain [PREFIX_ENTRIES+1];
  v4v6_pkg::carry_t fin;
  v4v6_pkg::wr_t wr;
  logic [1:0] status_next;
  logic [2:0] sel_code;
  logic [95:0] sel_pfx;
  logic done;

  assign req.ready = state == S_IDLE;
  assign rsp.valid = state == S_OUT;
  assign lc = v4v6_pkg::len_code(prefix_len);
  assign fin = chain[PREFIX_ENTRIES];
  assign done = state == S_SCAN && fin.go;

  always_comb begin
    chain[0] = '0;
    chain[0].go = start;
  end

  for (genvar i = 0; i < PREFIX_ENTRIES; i++) begin : g_cell
    v4v6_cell #(.IDX(i)) u_cell (
      .clk(clk),
      .rst(rst),
      .action(action),
      .tenant_id(tenant_id),
      .table_index(table_index),
      .addr_high(addr_high),
      .addr_mid(addr_low[63:32]),
      .code(lc[2:0]),
      .wr(wr),
      .cin(chain[i]),
      .cout(chain[i+1])
    );
  end

  always_comb begin
    wr = '0;
    status_next = v4v6_pkg::ST_OK;
    if (!action[1]) begin
      if (!lc[3]) begin
        status_next = v4v6_pkg::ST_BAD_LEN;
      end else if (action == v4v6_pkg::ACT_ADD) begin
        if (fin.hit) begin
          wr.en = done;
          wr.idx = fin.hit_idx;
        end else if (fin.free) begin
          wr.en = done;
          wr.fresh = 1'b1;
          wr.idx = fin.free_idx;
        end else begin
          status_next = v4v6_pkg::ST_FULL;
        end
      end else if (fin.hit) begin
        wr.en = done;
        wr.clear = 1'b1;
        wr.idx = fin.hit_idx;
      end else begin
        status_next = v4v6_pkg::ST_NO_ENTRY;
      end
    end
    if (fin.hit) begin
      sel_code = fin.hit_code;
      sel_pfx = {fin.hit_hi, fin.hit_mid};
    end else if (fin.fb) begin
      sel_code = fin.fb_code;
      sel_pfx = {fin.fb_hi, fin.fb_mid};
    end else begin
      sel_code = v4v6_pkg::CODE_96;
      sel_pfx = v4v6_pkg::WKP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      start <= 1'b0;
    end else begin
      start <= req.valid && req.ready;
      case (state)
        S_IDLE: if (req.valid) state <= S_SCAN;
        S_SCAN: if (fin.go) state <= S_OUT;
        S_OUT: if (rsp.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      action <= req.action;
      tenant_id <= req.tenant_id;
      table_index <= req.table_index;
      addr_high <= req.addr_high;
      addr_low <= req.addr_low;
      prefix_len <= req.prefix_len;
      ipv4_addr <= req.ipv4_addr;
    end
    if (done) begin
      rsp.status <= status_next;
      {rsp.ipv6_high, rsp.ipv6_low} <= (action == v4v6_pkg::ACT_CMP) ?
          v4v6_pkg::compose(sel_code, sel_pfx, ipv4_addr) : 128'd0;
      rsp.ipv4_out <= (action == v4v6_pkg::ACT_EXT) ?
          v4v6_pkg::extract(sel_code, {addr_high, addr_low}) : 32'd0;
    end
  end
endmodule
